// ===== src/fst_pkg.sv =====
// Shared types, codes and constants of the format string tokenizer.
package fst_pkg;

  // Deepest allowed nesting of conditional blocks.
  localparam int MAX_DEPTH = 255;
  localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);

  // Entries of the queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Most results that one byte causes.
  localparam int MAX_RES = 3;
  localparam int RIDX_W  = $clog2(MAX_RES);
  localparam int RCNT_W  = $clog2(MAX_RES + 1);

  localparam logic [1:0] CFG_ADDR_ALLOW = 2'd0;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_D      = 8'h64;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_B      = 8'h62;

  typedef enum logic [2:0] {
    KIND_LIT   = 3'd0,
    KIND_SPEC  = 3'd1,
    KIND_BEGIN = 3'd2,
    KIND_END   = 3'd3,
    KIND_DONE  = 3'd4,
    KIND_ERR   = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_END_NOBEGIN = 3'd1,
    ERR_INVALID     = 3'd2,
    ERR_OPEN        = 3'd3,
    ERR_STRAY_CLOSE = 3'd4,
    ERR_BEGIN_OPEN  = 3'd5,
    ERR_OVERFLOW    = 3'd6
  } err_e;

  localparam logic [3:0] PREF_DEFAULT = 4'd0;

  // Wait states carry the pending preference in their low four bits.
  typedef enum logic [4:0] {
    ST_IDLE   = 5'd0,
    ST_CLOSE  = 5'd1,
    ST_OPEN   = 5'd2,
    ST_QMARK  = 5'd3,
    ST_SLASH  = 5'd4,
    ST_COLON  = 5'd5,
    ST_COLZ   = 5'd6,
    ST_COLH   = 5'd7,
    ST_SEARCH = 5'd8,
    ST_DROP   = 5'd9,
    ST_W_UDEC = 5'd17,
    ST_W_SDEC = 5'd18,
    ST_W_HEX  = 5'd19,
    ST_W_ZHEX = 5'd20,
    ST_W_PHEX = 5'd21,
    ST_W_BIN  = 5'd22,
    ST_W_ZBIN = 5'd23,
    ST_W_PBIN = 5'd24
  } state_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  ch;
    logic [3:0]  pref;
    err_e        err;
  } result_t;

  typedef struct packed {
    logic [RCNT_W-1:0]       cnt;
    result_t [MAX_RES-1:0]   res;
  } entry_t;

  function automatic result_t make_res(kind_e kind, logic [7:0] ch, logic [3:0] pref,
                                       err_e err);
    result_t r;
    r.kind = kind;
    r.ch   = ch;
    r.pref = pref;
    r.err  = err;
    return r;
  endfunction

endpackage

// ===== src/format_string_tokenizer.sv =====
// Top level of the format string tokenizer: config register, front, queue and back.
// An accepted byte's results go into the group queue, then to the output register.
// Throughput: one byte and, while m_axis_tready is high, one result beat per cycle;
//   bytes of two or three beats fill the four-entry queue; input stalls only when full.
// Reset: asynchronous, active low; matcher idle, nesting zero, queue empty,
//   allow_control cleared.
module format_string_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
  input  logic        s_axis_tlast,   // last_char
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] char_value, [11:8] preference,
                                      // [14:12] error_code, [15] zero
  output logic [2:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast,   // run_last
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic             allow_q;
  logic             full, push, pop, avail;
  fst_pkg::entry_t  entry, head;
  fst_pkg::result_t res;

  assign pready = 1'b1;
  assign prdata = (paddr == fst_pkg::CFG_ADDR_ALLOW) ? {31'b0, allow_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allow_q <= 1'b0;
    end else if (psel && penable && pwrite && pready
                 && paddr == fst_pkg::CFG_ADDR_ALLOW) begin
      allow_q <= pwdata[0];
    end
  end

  fst_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .char_i  (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .allow_i (allow_q),
    .full_i  (full),
    .push_o  (push),
    .entry_o (entry)
  );

  fst_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head),
    .avail_o (avail)
  );

  fst_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (avail),
    .head_i  (head),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res),
    .last_o  (m_axis_tlast)
  );

  assign m_axis_tuser = res.kind;
  assign m_axis_tdata = {1'b0, res.err, res.pref, res.ch};

endmodule

// ===== src/fst_front.sv =====
// Front end: accepts bytes, runs the token matcher and queues result groups.
module fst_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic [7:0]               char_i,
  input  logic                     last_i,
  input  logic                     allow_i,
  input  logic                     full_i,
  output logic                     push_o,
  output fst_pkg::entry_t          entry_o
);

  fst_pkg::state_e              st_q, st_d, nxt;
  logic [fst_pkg::DEPTH_W-1:0]  depth_q, depth_d, depth_nx;
  logic                         in_acc;
  logic                         drop;
  logic                         fail;
  fst_pkg::err_e                err;
  logic [1:0]                   b_n;
  fst_pkg::result_t             b0, b1, tail;
  logic                         tail_v;

  assign ready_o = !full_i;
  assign in_acc  = valid_i && ready_o;

  // Next state and per-byte result group.
  always_comb begin
    nxt      = fst_pkg::ST_IDLE;
    depth_nx = depth_q;
    drop     = 1'b0;
    fail     = 1'b0;
    err      = fst_pkg::ERR_NONE;
    b_n      = 2'd0;
    b0       = '0;
    b1       = '0;
    unique case (st_q) inside
      fst_pkg::ST_DROP: begin
        drop = 1'b1;
      end
      fst_pkg::ST_IDLE: begin
        if (char_i == fst_pkg::CH_LBRACE) begin
          nxt = fst_pkg::ST_OPEN;
        end else if (char_i == fst_pkg::CH_RBRACE) begin
          nxt = fst_pkg::ST_CLOSE;
        end else begin
          b_n = 2'd1;
          b0  = fst_pkg::make_res(fst_pkg::KIND_LIT, char_i, fst_pkg::PREF_DEFAULT,
                                  fst_pkg::ERR_NONE);
        end
      end
      fst_pkg::ST_CLOSE: begin
        if (char_i == fst_pkg::CH_RBRACE) begin
          b_n = 2'd2;
          b0  = fst_pkg::make_res(fst_pkg::KIND_LIT, fst_pkg::CH_RBRACE,
                                  fst_pkg::PREF_DEFAULT, fst_pkg::ERR_NONE);
          b1  = b0;
        end else begin
          err = fst_pkg::ERR_STRAY_CLOSE;
        end
      end
      fst_pkg::ST_OPEN: begin
        if (char_i == fst_pkg::CH_LBRACE) begin
          b_n = 2'd2;
          b0  = fst_pkg::make_res(fst_pkg::KIND_LIT, fst_pkg::CH_LBRACE,
                                  fst_pkg::PREF_DEFAULT, fst_pkg::ERR_NONE);
          b1  = b0;
        end else if (char_i == fst_pkg::CH_RBRACE) begin
          b_n = 2'd1;
          b0  = fst_pkg::make_res(fst_pkg::KIND_SPEC, 8'h00, fst_pkg::PREF_DEFAULT,
                                  fst_pkg::ERR_NONE);
        end else if (char_i == fst_pkg::CH_QMARK && allow_i) begin
          nxt = fst_pkg::ST_QMARK;
        end else if (char_i == fst_pkg::CH_SLASH && allow_i) begin
          nxt = fst_pkg::ST_SLASH;
        end else if (char_i == fst_pkg::CH_COLON) begin
          nxt = fst_pkg::ST_COLON;
        end else begin
          fail = 1'b1;
        end
      end
      fst_pkg::ST_QMARK: begin
        if (char_i != fst_pkg::CH_RBRACE) begin
          fail = 1'b1;
        end else if (depth_q >= fst_pkg::DEPTH_W'(fst_pkg::MAX_DEPTH)) begin
          err = fst_pkg::ERR_OVERFLOW;
        end else begin
          depth_nx = depth_q + 1'b1;
          b_n      = 2'd1;
          b0       = fst_pkg::make_res(fst_pkg::KIND_BEGIN, 8'h00, fst_pkg::PREF_DEFAULT,
                                       fst_pkg::ERR_NONE);
        end
      end
      fst_pkg::ST_SLASH: begin
        if (char_i != fst_pkg::CH_RBRACE) begin
          fail = 1'b1;
        end else if (depth_q == '0) begin
          err = fst_pkg::ERR_END_NOBEGIN;
        end else begin
          depth_nx = depth_q - 1'b1;
          b_n      = 2'd1;
          b0       = fst_pkg::make_res(fst_pkg::KIND_END, 8'h00, fst_pkg::PREF_DEFAULT,
                                       fst_pkg::ERR_NONE);
        end
      end
      fst_pkg::ST_COLON: begin
        if (char_i == fst_pkg::CH_U) begin
          nxt = fst_pkg::ST_W_UDEC;
        end else if (char_i == fst_pkg::CH_D) begin
          nxt = fst_pkg::ST_W_SDEC;
        end else if (char_i == fst_pkg::CH_X) begin
          nxt = fst_pkg::ST_W_HEX;
        end else if (char_i == fst_pkg::CH_ZERO) begin
          nxt = fst_pkg::ST_COLZ;
        end else if (char_i == fst_pkg::CH_HASH) begin
          nxt = fst_pkg::ST_COLH;
        end else if (char_i == fst_pkg::CH_B) begin
          nxt = fst_pkg::ST_W_BIN;
        end else begin
          fail = 1'b1;
        end
      end
      fst_pkg::ST_COLZ: begin
        if (char_i == fst_pkg::CH_X) begin
          nxt = fst_pkg::ST_W_ZHEX;
        end else if (char_i == fst_pkg::CH_B) begin
          nxt = fst_pkg::ST_W_ZBIN;
        end else begin
          fail = 1'b1;
        end
      end
      fst_pkg::ST_COLH: begin
        if (char_i == fst_pkg::CH_X) begin
          nxt = fst_pkg::ST_W_PHEX;
        end else if (char_i == fst_pkg::CH_B) begin
          nxt = fst_pkg::ST_W_PBIN;
        end else begin
          fail = 1'b1;
        end
      end
      fst_pkg::ST_SEARCH: begin
        fail = 1'b1;
      end
      fst_pkg::ST_W_UDEC, fst_pkg::ST_W_SDEC, fst_pkg::ST_W_HEX, fst_pkg::ST_W_ZHEX,
      fst_pkg::ST_W_PHEX, fst_pkg::ST_W_BIN, fst_pkg::ST_W_ZBIN, fst_pkg::ST_W_PBIN: begin
        if (char_i == fst_pkg::CH_RBRACE) begin
          b_n = 2'd1;
          b0  = fst_pkg::make_res(fst_pkg::KIND_SPEC, 8'h00, st_q[3:0], fst_pkg::ERR_NONE);
        end else begin
          fail = 1'b1;
        end
      end
      default: begin
        drop = 1'b1;
      end
    endcase

    // A failed token waits for a closing brace or the end of the string.
    if (fail) begin
      if (char_i == fst_pkg::CH_RBRACE) begin
        err = fst_pkg::ERR_INVALID;
      end else if (last_i) begin
        err = fst_pkg::ERR_OPEN;
      end else begin
        nxt = fst_pkg::ST_SEARCH;
      end
    end

    tail_v = 1'b0;
    tail   = '0;
    if (err != fst_pkg::ERR_NONE) begin
      tail_v = 1'b1;
      tail   = fst_pkg::make_res(fst_pkg::KIND_ERR, 8'h00, fst_pkg::PREF_DEFAULT, err);
      nxt    = fst_pkg::ST_DROP;
    end else if (last_i) begin
      tail_v = 1'b1;
      if (nxt == fst_pkg::ST_CLOSE) begin
        tail = fst_pkg::make_res(fst_pkg::KIND_ERR, 8'h00, fst_pkg::PREF_DEFAULT,
                                 fst_pkg::ERR_STRAY_CLOSE);
      end else if (nxt != fst_pkg::ST_IDLE) begin
        tail = fst_pkg::make_res(fst_pkg::KIND_ERR, 8'h00, fst_pkg::PREF_DEFAULT,
                                 fst_pkg::ERR_OPEN);
      end else if (depth_nx != '0) begin
        tail = fst_pkg::make_res(fst_pkg::KIND_ERR, 8'h00, fst_pkg::PREF_DEFAULT,
                                 fst_pkg::ERR_BEGIN_OPEN);
      end else begin
        tail = fst_pkg::make_res(fst_pkg::KIND_DONE, 8'h00, fst_pkg::PREF_DEFAULT,
                                 fst_pkg::ERR_NONE);
      end
    end

    if (drop) begin
      tail_v = 1'b0;
      b_n    = 2'd0;
    end

    if (last_i) begin
      st_d    = fst_pkg::ST_IDLE;
      depth_d = '0;
    end else if (drop) begin
      st_d    = st_q;
      depth_d = depth_q;
    end else begin
      st_d    = nxt;
      depth_d = depth_nx;
    end
  end

  // Pack the group: body results first, then the closing result.
  always_comb begin
    entry_o.cnt    = fst_pkg::RCNT_W'(b_n) + fst_pkg::RCNT_W'(tail_v);
    entry_o.res[0] = b0;
    entry_o.res[1] = b1;
    entry_o.res[2] = '0;
    case (b_n)
      2'd0:    entry_o.res[0] = tail;
      2'd1:    entry_o.res[1] = tail;
      default: entry_o.res[2] = tail;
    endcase
  end

  assign push_o = in_acc && (entry_o.cnt != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= fst_pkg::ST_IDLE;
      depth_q <= '0;
    end else if (in_acc) begin
      st_q    <= st_d;
      depth_q <= depth_d;
    end
  end

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_i) |=> (st_q == fst_pkg::ST_IDLE && depth_q == '0))
    else $error("matcher not back at idle after last byte");

  a_drop_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && st_q == fst_pkg::ST_DROP) |-> !push_o)
    else $error("result queued while dropping");

  a_last_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_i && st_q != fst_pkg::ST_DROP) |-> push_o)
    else $error("last byte of a string gave no closing result");

endmodule

// ===== src/fst_queue.sv =====
// Short queue of result groups between the matcher and the output side.
module fst_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fst_pkg::entry_t  entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output fst_pkg::entry_t  head_o,
  output logic             avail_o
);

  fst_pkg::entry_t             mem_q [fst_pkg::QDEPTH];
  logic [fst_pkg::QPTR_W-1:0]  wr_q, rd_q;
  logic [fst_pkg::QCNT_W-1:0]  cnt_q;

  function automatic logic [fst_pkg::QPTR_W-1:0] ptr_inc(logic [fst_pkg::QPTR_W-1:0] p);
    if (p == fst_pkg::QPTR_W'(fst_pkg::QDEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == fst_pkg::QCNT_W'(fst_pkg::QDEPTH));
  assign avail_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ptr_inc(wr_q);
      end
      if (pop_i) begin
        rd_q <= ptr_inc(rd_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> avail_o)
    else $error("pop from empty queue");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= fst_pkg::QCNT_W'(fst_pkg::QDEPTH))
    else $error("queue count out of range");

endmodule

// ===== src/fst_back.sv =====
// Back end: unpacks queued result groups into beats, one per ready cycle.
module fst_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             avail_i,
  input  fst_pkg::entry_t  head_i,
  output logic             pop_o,
  output logic             valid_o,
  input  logic             ready_i,
  output fst_pkg::result_t res_o,
  output logic             last_o
);

  logic [fst_pkg::RIDX_W-1:0] idx_q;
  logic                       load;
  logic                       grp_end;
  logic                       valid_q;
  fst_pkg::result_t           res_q;
  logic                       last_q;

  assign load    = avail_i && (!valid_q || ready_i);
  assign grp_end = (fst_pkg::RCNT_W'(idx_q) == head_i.cnt - 1'b1);
  assign pop_o   = load && grp_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= grp_end ? '0 : idx_q + 1'b1;
      end else if (ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q  <= head_i.res[idx_q];
      last_q <= grp_end;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;
  assign last_o  = last_q;

  a_pop_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (load && head_i.cnt != '0))
    else $error("group popped without its last beat");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    avail_i |-> (fst_pkg::RCNT_W'(idx_q) < head_i.cnt))
    else $error("beat index past group size");

  a_load_sets_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (valid_q && last_q))
    else $error("group end not marked on output");

endmodule
